@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on aclk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define LSL_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold at the same edge.
`define LSL_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/lsl_pkg.sv @@
// ----------------------------------------------------------------------------
// Soft limiter package
// Types, constants and elaboration-time log table functions for the limiter.
// ----------------------------------------------------------------------------
package lsl_pkg;

    localparam int SAMPLE_W     = 22;
    localparam int PCM_W        = 16;
    localparam int FRAC_W       = 30;
    localparam int LANE_STAGES  = 10;

    localparam logic [SAMPLE_W-1:0] KNEE_Q4     = 22'd262136;
    localparam logic [31:0]         LN2_Q30     = 32'd744261118;
    localparam logic [31:0]         LN2_X2_Q30  = 32'd1488522236;
    localparam logic [14:0]         HALF_SCALE  = 15'd32767;
    localparam logic [47:0]         HALF_OFFSET = 48'd32767 << 30;
    localparam logic [30:0]         HALF_Q31    = 31'h4000_0000;
    localparam logic [33:0]         U_ONE       = 34'h0_4000_0000;

    localparam logic [1:0] CHANNELS_MONO   = 2'd1;
    localparam logic [1:0] CHANNELS_STEREO = 2'd2;

    typedef struct packed {
        logic [FRAC_W-1:0] step;
        logic [FRAC_W-1:0] base;
    } rom_entry_t;

    typedef struct packed {
        logic        neg;
        logic        below;
        logic [14:0] rsmall;
    } side_t;

    typedef struct packed {
        logic             last;
        logic [PCM_W-1:0] right;
        logic [PCM_W-1:0] left;
    } pcm_frame_t;

    // Restoring division, used only to build the log table at elaboration.
    function automatic logic [63:0] lsl_udiv64(input logic [63:0] num,
                                               input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // ln(1 + i/n) in Q30 from the atanh series with truncated terms.
    function automatic logic [63:0] lsl_log_entry(input int unsigned n,
                                                  input int unsigned i);
        logic [63:0] zq;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] k;
        zq   = lsl_udiv64(64'(i) << 30, 64'(2 * n + i));
        z2   = (zq * zq) >> 30;
        term = zq;
        sum  = '0;
        k    = 64'd1;
        for (int it = 0; it < 24; it++) begin
            if (term != 64'd0) begin
                sum  = sum + lsl_udiv64(term, k);
                term = (term * z2) >> 30;
                k    = k + 64'd2;
            end
        end
        return sum << 1;
    endfunction

endpackage

@@ hdl/lsl_log_rom.sv @@
// ----------------------------------------------------------------------------
// Log table ROM
// Holds ln(1 + i/N) in Q30 and the step to the next entry, registered read.
// ----------------------------------------------------------------------------
module lsl_log_rom
    import lsl_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    output rom_entry_t               entry_out
);

    rom_entry_t rom [DEPTH];
    rom_entry_t rd_reg;

    genvar gi;
    for (gi = 0; gi < DEPTH; gi++) begin : g_rom
        localparam logic [63:0] LO = lsl_log_entry(DEPTH, gi);
        localparam logic [63:0] HI = lsl_log_entry(DEPTH, gi + 1);
        assign rom[gi] = '{step: FRAC_W'(HI - LO), base: LO[FRAC_W-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_reg <= rom[addr];
        end
    end

    assign entry_out = rd_reg;

endmodule

@@ hdl/lsl_lane.sv @@
// ----------------------------------------------------------------------------
// Soft limiter lane
// Ten-stage pipeline that limits, rounds and saturates one sample.
// ----------------------------------------------------------------------------
module lsl_lane
    import lsl_pkg::*;
#(
    parameter int LOG_TABLE_DEPTH = 1024
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    output logic signed [PCM_W-1:0]    pcm_out
);

    localparam int IDX_W = $clog2(LOG_TABLE_DEPTH);
    localparam int NW    = $clog2(LOG_TABLE_DEPTH + 1);
    localparam int P_W   = 32 + NW;
    localparam logic [NW-1:0] N_C = NW'(LOG_TABLE_DEPTH);
    localparam int SIDE_DEPTH = 8;

    // Stage 1: magnitude and knee test.
    logic [SAMPLE_W-1:0] raw;
    logic                neg_next;
    logic [SAMPLE_W-1:0] a_next;
    logic                neg1_reg;
    logic                below1_reg;
    logic [SAMPLE_W-1:0] a1_reg;

    // Stage 2: small-path rounding and scaled excess.
    logic [3:0]  small_rem;
    logic        small_up;
    logic [20:0] d_val;
    side_t       side_next;
    logic [22:0] m_next;
    logic [22:0] m2_reg;
    side_t       side_reg [SIDE_DEPTH];

    // Stage 3: division of the excess by 32767 through folding.
    logic [17:0] t_val;
    logic [18:0] r1_val;
    logic [3:0]  t2_val;
    logic [15:0] r2_val;
    logic        cor_val;
    logic [18:0] qs_val;
    logic [33:0] u_next;
    logic [33:0] u3_reg;

    // Stage 4: range reduction.
    logic [1:0]  e_next;
    logic [31:0] f_next;
    logic [31:0] f4_reg;
    logic [1:0]  e4_reg;

    // Stage 5: table position.
    logic [P_W-1:0] f_ext;
    logic [P_W-1:0] n_ext;
    logic [P_W-1:0] p_next;
    logic [P_W-1:0] p5_reg;
    logic [1:0]     e5_reg;

    // Stage 6: table read.
    logic [P_W-1:0]    ps_val;
    logic [IDX_W-1:0]  idx_val;
    logic [FRAC_W-1:0] frac6_reg;
    logic [1:0]        e6_reg;
    rom_entry_t        rom_q;

    // Stage 7: interpolation product.
    logic [59:0]       prod_next;
    logic [59:0]       prod7_reg;
    logic [FRAC_W-1:0] base7_reg;
    logic [1:0]        e7_reg;

    // Stage 8: natural log sum.
    logic [31:0] ln2_term;
    logic [31:0] lnv_next;
    logic [31:0] lnv8_reg;

    // Stage 9: scale by the knee.
    logic [46:0] mp_next;
    logic [46:0] mp9_reg;

    // Stage 10: round half to even, saturate, restore the sign.
    logic [47:0]      tot_val;
    logic [16:0]      ip_val;
    logic [30:0]      rem_val;
    logic             big_up;
    logic [16:0]      r_val;
    logic [16:0]      r_sat;
    logic [PCM_W-1:0] pcm_next;
    logic [PCM_W-1:0] pcm10_reg;
    side_t            side_last;

    always_comb begin
        raw      = sample_in;
        neg_next = raw[SAMPLE_W-1];
        a_next   = neg_next ? SAMPLE_W'(~raw + 22'd1) : raw;
    end

    always_comb begin
        small_rem = a1_reg[3:0];
        small_up  = (small_rem > 4'd8) || ((small_rem == 4'd8) && a1_reg[4]);
        side_next = '{neg: neg1_reg, below: below1_reg,
                      rsmall: 15'(a1_reg[21:4]) + 15'(small_up)};
        d_val     = 21'(a1_reg - KNEE_Q4);
        m_next    = {1'b0, d_val, 1'b0} + {2'b0, d_val};
    end

    // floor(m * 1024 / 32767): fold the 2^15 digits back in twice.
    always_comb begin
        t_val   = m2_reg[22:5];
        r1_val  = {4'b0, m2_reg[4:0], 10'b0} + {1'b0, t_val};
        t2_val  = r1_val[18:15];
        r2_val  = {1'b0, r1_val[14:0]} + 16'(t2_val);
        cor_val = (r2_val >= 16'd32767);
        qs_val  = 19'(t_val) + 19'(t2_val) + 19'(cor_val);
        u_next  = U_ONE + {1'b0, m2_reg, 10'b0} + 34'(qs_val);
    end

    always_comb begin
        if (u3_reg[32]) begin
            e_next = 2'd2;
        end else if (u3_reg[31]) begin
            e_next = 2'd1;
        end else begin
            e_next = 2'd0;
        end
        f_next = 32'(u3_reg - (U_ONE << e_next));
    end

    always_comb begin
        f_ext  = P_W'(f4_reg);
        n_ext  = P_W'(N_C);
        p_next = f_ext * n_ext;
    end

    always_comb begin
        ps_val  = p5_reg >> e5_reg;
        idx_val = ps_val[FRAC_W +: IDX_W];
    end

    lsl_log_rom #(
        .DEPTH (LOG_TABLE_DEPTH)
    ) u_rom (
        .aclk      (aclk),
        .en        (en),
        .addr      (idx_val),
        .entry_out (rom_q)
    );

    always_comb begin
        prod_next = 60'(rom_q.step) * 60'(frac6_reg);
    end

    always_comb begin
        case (e7_reg)
            2'd1:    ln2_term = LN2_Q30;
            2'd2:    ln2_term = LN2_X2_Q30;
            default: ln2_term = 32'd0;
        endcase
        lnv_next = 32'(base7_reg) + 32'(prod7_reg[59:30]) + ln2_term;
    end

    always_comb begin
        mp_next = 47'(HALF_SCALE) * 47'(lnv8_reg);
    end

    always_comb begin
        side_last = side_reg[SIDE_DEPTH-1];
        tot_val   = HALF_OFFSET + 48'(mp9_reg);
        ip_val    = tot_val[47:31];
        rem_val   = tot_val[30:0];
        big_up    = (rem_val > HALF_Q31) || ((rem_val == HALF_Q31) && ip_val[0]);
        r_val     = side_last.below ? {2'b0, side_last.rsmall} : ip_val + 17'(big_up);
        if (side_last.neg) begin
            r_sat    = (r_val > 17'd32768) ? 17'd32768 : r_val;
            pcm_next = PCM_W'(~r_sat + 17'd1);
        end else begin
            r_sat    = (r_val > 17'd32767) ? 17'd32767 : r_val;
            pcm_next = PCM_W'(r_sat);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg   <= neg_next;
            below1_reg <= (a_next <= KNEE_Q4);
            a1_reg     <= a_next;
            m2_reg     <= m_next;
            side_reg[0] <= side_next;
            for (int s = 1; s < SIDE_DEPTH; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
            u3_reg    <= u_next;
            f4_reg    <= f_next;
            e4_reg    <= e_next;
            p5_reg    <= p_next;
            e5_reg    <= e4_reg;
            frac6_reg <= ps_val[FRAC_W-1:0];
            e6_reg    <= e5_reg;
            prod7_reg <= prod_next;
            base7_reg <= rom_q.base;
            e7_reg    <= e6_reg;
            lnv8_reg  <= lnv_next;
            mp9_reg   <= mp_next;
            pcm10_reg <= pcm_next;
        end
    end

    assign pcm_out = pcm10_reg;

endmodule

@@ hdl/lsl_merge.sv @@
// ----------------------------------------------------------------------------
// Soft limiter merge stage
// Combines the two lane results, applies mono copy, output register and skid.
// ----------------------------------------------------------------------------
module lsl_merge
    import lsl_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    mono,
    input  logic                    in_valid,
    input  pcm_frame_t              in_frame,
    output logic                    advance,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [2*PCM_W-1:0]      m_tdata,
    output logic                    m_tlast
);

    pcm_frame_t frame_next;
    logic       take;
    logic       held;
    logic       out_valid_reg;
    logic       skid_valid_reg;
    pcm_frame_t out_data_reg;
    pcm_frame_t skid_data_reg;

    always_comb begin
        frame_next = in_frame;
        if (mono) begin
            frame_next.right = in_frame.left;
        end
    end

    // The pipeline moves only while the skid stage is empty.
    assign advance = !skid_valid_reg;
    assign take    = in_valid && advance;
    assign held    = out_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (held) begin
            if (take) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (held) begin
            if (take) begin
                skid_data_reg <= frame_next;
            end
        end else if (skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end else if (take) begin
            out_data_reg <= frame_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.right, out_data_reg.left};
    assign m_tlast  = out_data_reg.last;

endmodule

@@ hdl/log_soft_limiter_pcm16_out_unit.sv @@
// ----------------------------------------------------------------------------
// Logarithmic soft limiter, 16-bit PCM out
// An accepted item enters the first of 10 lane stages at the accepting edge,
// then the output register that drives m_tvalid. Throughput: one stereo item
// per cycle while the skid stage is empty, set by the fully pipelined lanes.
// Reset: aresetn (synchronous, active low) empties the pipeline and the
// output stage and sets channel_count to stereo; the table needs no fill.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module log_soft_limiter_pcm16_out_unit
    import lsl_pkg::*;
#(
    parameter int LOG_TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,    // channel_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,     // left_sample [21:0], right_sample [43:22]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // left_out [15:0], right_out [31:16]
    output logic        m_tlast
);

    logic [1:0]             channel_count_reg;
    logic                   en;
    logic [LANE_STAGES-1:0] vld_reg;
    logic [LANE_STAGES-1:0] last_reg;
    logic signed [PCM_W-1:0] left_pcm;
    logic signed [PCM_W-1:0] right_pcm;
    pcm_frame_t             lane_frame;
    logic                   out_held;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= CHANNELS_STEREO;
        end else if (cfg_valid && cfg_ready) begin
            channel_count_reg <= cfg_data;
        end
    end

    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LANE_STAGES-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last_reg <= {last_reg[LANE_STAGES-2:0], s_tlast};
        end
    end

    lsl_lane #(
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
    ) u_lane_left (
        .aclk      (aclk),
        .en        (en),
        .sample_in ($signed(s_tdata[21:0])),
        .pcm_out   (left_pcm)
    );

    lsl_lane #(
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
    ) u_lane_right (
        .aclk      (aclk),
        .en        (en),
        .sample_in ($signed(s_tdata[43:22])),
        .pcm_out   (right_pcm)
    );

    assign lane_frame = '{last: last_reg[LANE_STAGES-1], right: right_pcm, left: left_pcm};

    lsl_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mono     (channel_count_reg <= CHANNELS_MONO),
        .in_valid (vld_reg[LANE_STAGES-1]),
        .in_frame (lane_frame),
        .advance  (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assign out_held = m_tvalid && !m_tready;

    // A stalled input side always has a result waiting at the output.
    `LSL_ASSERT_ALWAYS(a_stall_has_item, s_tready || m_tvalid, "input stalled with empty output")
    // Ready drops only after an edge at which the output was held.
    `LSL_ASSERT_IMPLIES(a_ready_fall, $fell(s_tready), $past(out_held), "ready fell, no stall")
    // Ready returns only after the output item was taken.
    `LSL_ASSERT_IMPLIES(a_ready_rise, $rose(s_tready), $past(m_tready), "rose without handshake")

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soft limiter testbench
// Streams stereo frames through the limiter under random bursts and output
// stalls, predicts each PCM frame from a local log table and compares every
// output item field by field, across all channel_count settings.
// ----------------------------------------------------------------------------
module tb;
    import lsl_pkg::*;

    localparam int          PIPE_LATENCY   = 11;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          MAX_PRINTS     = 40;
    localparam int          RANDOM_FRAMES  = 115;
    localparam int          TABLE_N        = 1024;
    localparam logic [63:0] KNEE_MAG       = 64'd262136;
    localparam logic [63:0] KNEE_DEN       = 64'd1048544;
    localparam logic [63:0] LN2_FIX        = 64'd744261118;
    localparam logic [63:0] PCM_SCALE      = 64'd32767;
    localparam logic [1:0]  CHANNELS_ZERO  = 2'd0;
    localparam logic [1:0]  CHANNELS_THREE = 2'd3;

    typedef struct packed {
        logic                last;
        logic [SAMPLE_W-1:0] right;
        logic [SAMPLE_W-1:0] left;
    } stereo_in_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data  = 2'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;   // left_sample [21:0], right_sample [43:22]
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // left_out [15:0], right_out [31:16]
    logic        m_tlast;

    log_soft_limiter_pcm16_out_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [63:0] ln_table [0:TABLE_N];
    stereo_in_t  frames_to_send [$];
    pcm_frame_t  pcm_expected [$];
    logic [1:0]  channel_setting;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;

    // ln(1 + i/N) in Q30 via the atanh series, every step truncated.
    initial begin
        logic [63:0] zq, z2, term, acc, k;
        for (int i = 0; i <= TABLE_N; i++) begin
            zq   = (64'(i) << 30) / (64'(2 * TABLE_N) + 64'(i));
            z2   = (zq * zq) >> 30;
            term = zq;
            acc  = '0;
            k    = 64'd1;
            while (term != 64'd0) begin
                acc  = acc + term / k;
                term = (term * z2) >> 30;
                k    = k + 64'd2;
            end
            ln_table[i] = acc << 1;
        end
    end

    function automatic logic [63:0] round_half_even(input logic [63:0] q, input int s);
        logic [63:0] ip;
        logic [63:0] rem;
        logic [63:0] half;
        ip   = q >> s;
        rem  = q & ((64'd1 << s) - 64'd1);
        half = 64'd1 << (s - 1);
        if (rem > half || (rem == half && ip[0]))
            ip = ip + 64'd1;
        return ip;
    endfunction

    function automatic logic [PCM_W-1:0] limit_sample(input logic [SAMPLE_W-1:0] raw);
        logic        neg;
        logic [63:0] mag, excess, u, f, p, idx, frac, lnv, r;
        int          e;
        neg = raw[SAMPLE_W-1];
        mag = neg ? (64'h40_0000 - 64'(raw)) : 64'(raw);
        if (mag <= KNEE_MAG) begin
            r = round_half_even(mag, 4);
        end else begin
            excess = mag - KNEE_MAG;
            u = (64'd1 << 30) + (((64'd3 * excess) << 30) / KNEE_DEN);
            e = 0;
            // Bring u into [1,2); each halving adds ln 2 to the result.
            while ((u >> e) >= (64'd2 << 30))
                e++;
            f   = u - ((64'd1 << 30) << e);
            p   = f * 64'(TABLE_N);
            idx = p >> (30 + e);
            if (idx >= 64'(TABLE_N))
                idx = 64'(TABLE_N - 1);
            frac = (p - (idx << (30 + e))) >> e;
            lnv  = ln_table[idx] + (((ln_table[idx + 1] - ln_table[idx]) * frac) >> 30)
                 + 64'(e) * LN2_FIX;
            r = round_half_even(PCM_SCALE * (64'd1 << 30) + PCM_SCALE * lnv, 31);
        end
        if (neg) begin
            if (r > 64'd32768)
                r = 64'd32768;
            return 16'(64'h1_0000 - r);
        end
        if (r > 64'd32767)
            r = 64'd32767;
        return r[PCM_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        logic [SAMPLE_W-1:0] mag;
        case ($urandom_range(0, 7))
            0, 1: return 22'($urandom());
            2: mag = 22'(KNEE_MAG) - 22'd40 + 22'($urandom_range(0, 80));
            3: mag = 22'($urandom_range(262137, 2097151));
            4: mag = 22'($urandom_range(0, 4095));
            5: mag = 22'($urandom_range(0, 16382)) * 22'd16 + 22'd8;
            6: mag = 22'd2097151 - 22'($urandom_range(0, 300));
            default: mag = 22'($urandom_range(0, 262136));
        endcase
        return $urandom_range(0, 1) ? (22'd0 - mag) : mag;
    endfunction

    task automatic push_frame(input int l, input int r, input bit last);
        frames_to_send.push_back('{last: last, right: 22'(r), left: 22'(l)});
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_channels(input logic [1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Checked at the falling edge, after every update of the rising edge.
    task automatic wait_drained();
        do @(negedge aclk);
        while (frames_to_send.size() != 0 || s_tvalid || pcm_expected.size() != 0);
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;
    always @(posedge aclk) begin
        stereo_in_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (frames_to_send.size() != 0) begin
                item = frames_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'd0, item.right, item.left};
                s_tlast  <= item.last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switches between always ready, a periodic stall and random stalls.
    int stall_mode  = 0;
    int stall_count = 0;
    int cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (stall_count == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            stall_count <= $urandom_range(16, 96);
        end else begin
            stall_count <= stall_count - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= (cycle_count % 3) != 0;
            2: m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn)
            channel_setting <= CHANNELS_STEREO;
        else if (cfg_valid && cfg_ready)
            channel_setting <= cfg_data;
    end

    // Expected frame for every accepted input item.
    always @(posedge aclk) begin
        pcm_frame_t want;
        if (aresetn && s_tvalid && s_tready) begin
            want.left  = limit_sample(s_tdata[21:0]);
            want.right = (channel_setting <= CHANNELS_MONO) ? want.left
                                                            : limit_sample(s_tdata[43:22]);
            want.last  = s_tlast;
            pcm_expected.push_back(want);
        end
    end

    always @(posedge aclk) begin
        pcm_frame_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pcm_expected.size() == 0) begin
                report_mismatch("unexpected item", int'(m_tdata), 0);
            end else begin
                want = pcm_expected.pop_front();
                if (m_tdata[15:0] !== want.left)
                    report_mismatch("left_out", int'($signed(m_tdata[15:0])),
                                    int'($signed(want.left)));
                if (m_tdata[31:16] !== want.right)
                    report_mismatch("right_out", int'($signed(m_tdata[31:16])),
                                    int'($signed(want.right)));
                if (m_tlast !== want.last)
                    report_mismatch("last_out", int'(m_tlast), int'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [1:0] settings [5];
        settings = '{CHANNELS_STEREO, CHANNELS_MONO, CHANNELS_ZERO, CHANNELS_THREE,
                     CHANNELS_STEREO};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < 5; ph++) begin
            // The first phase runs on the reset value of channel_count.
            if (ph != 0)
                write_channels(settings[ph]);
            if (ph == 0) begin
                push_frame(0, 0, 1'b0);
                push_frame(1, -1, 1'b1);
                // Ties at one half: 0.5 rounds down to 0, 1.5 up to 2.
                push_frame(8, 24, 1'b0);
                push_frame(262120, -262120, 1'b0);
                // Exactly at the knee the sample passes and 16383.5 rounds to 16384.
                push_frame(262136, -262136, 1'b1);
                push_frame(262137, -262137, 1'b0);
                push_frame(262135, 262152, 1'b0);
                push_frame(2097151, -2097152, 1'b1);
                push_frame(-2097151, 2097151, 1'b0);
                push_frame(1048576, -1048576, 1'b0);
                push_frame(-8, -24, 1'b1);
                push_frame(400000, -400000, 1'b0);
                push_frame(-1, 1, 1'b0);
            end else begin
                // Mono must ignore the right sample entirely.
                push_frame(2097151, -2097152, 1'b1);
                push_frame(-262137, 262136, 1'b0);
                push_frame(24, 2097151, 1'b0);
            end
            for (int n = 0; n < RANDOM_FRAMES; n++)
                push_frame(int'($signed(rand_sample())), int'($signed(rand_sample())),
                           $urandom_range(0, 7) == 0);
            wait_drained();
        end

        if (pcm_expected.size() != 0)
            report_mismatch("missing items", 0, pcm_expected.size());
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/lsl_pkg.sv
hdl/lsl_log_rom.sv
hdl/lsl_lane.sv
hdl/lsl_merge.sv
hdl/log_soft_limiter_pcm16_out_unit.sv
test/tb.sv
